// ===== rtl/tlbptu_pkg.sv =====
// Package with sizes and types of the page translation unit.
`default_nettype none
package tlbptu_pkg;
  localparam int TLB_ENTRIES  = 16;
  localparam int PAGE_COUNT   = 1024;
  localparam int FRAME_COUNT  = 256;
  localparam int OFFSET_WIDTH = 10;
  localparam int ADDR_W  = 20;
  localparam int PADDR_W = 18;
  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int TLB_W   = $clog2(TLB_ENTRIES);
  localparam int EVP_W   = 10;
  localparam int STAMP_W = 32;

  typedef struct packed {
    logic [ADDR_W-1:0] virt_addr;
  } req_t;

  typedef struct packed {
    logic [PADDR_W-1:0] phys_addr;
    logic               tlb_hit;
    logic               page_fault;
    logic               evicted_valid;
    logic [EVP_W-1:0]   evicted_page;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/tlbptu_if.sv =====
// Valid/ready channel interface carrying one payload beat.
`default_nettype none
interface tlbptu_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tlb_page_translation_unit.sv =====
// Top level of the page translation unit: TLB, page map and frame replacement.
//
// Usage: the input channel carries one virtual address per beat; the output
// channel returns one translation beat for each input beat, in order. The
// cfg channel writes replacement_mode (0 FIFO, 1 LRU); the user must write it
// only while the unit is idle; the unit itself does not enforce this. One
// address is worked on at a time. It is served from the TLB on a hit, from
// the page map on a map hit, or with a free frame on a fault; once all
// frames are taken a fault evicts by FIFO or by an LRU scan of the frame
// stamp memory, one frame per cycle. A stale FIFO slot falls back to that
// scan. The TLB is searched combinationally; the page map and frame
// memories have registered reads.
// After reset a clearing pass writes every page map entry invalid and every
// stamp zero, one entry per cycle; no address is started during it. A result
// waits in the output register while the receiver stalls; the next address
// is held meanwhile in a one-beat input register and is started only once
// that result has left.
`default_nettype none
module tlb_page_translation_unit (
  input  wire logic clk,
  input  wire logic rst,
  tlbptu_if.sink    in_ch,
  tlbptu_if.source  out_ch,
  tlbptu_if.sink    cfg
);
  import tlbptu_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAP, S_MAPD, S_FIFO1, S_FIFO2, S_SCAN, S_SCAN_END,
    S_EVICT, S_EVICTD, S_WRITE
  } state_t;

  state_t state;
  logic mode;
  logic [PAGE_W-1:0] clr_idx;

  // Page map memory: valid bit and frame.
  logic [FRAME_W:0] pm_mem [PAGE_COUNT];
  logic [FRAME_W:0] pm_rd;
  logic [PAGE_W-1:0] pm_raddr;
  logic pm_we;
  logic [PAGE_W-1:0] pm_waddr;
  logic [FRAME_W:0] pm_wdata;
  // Frame owner, load order queue and stamps.
  logic [PAGE_W-1:0] own_mem [FRAME_COUNT];
  logic [PAGE_W-1:0] own_rd;
  logic [FRAME_W-1:0] own_raddr;
  logic own_we;
  logic [PAGE_W-1:0] q_mem [FRAME_COUNT];
  logic [PAGE_W-1:0] q_rd;
  logic [STAMP_W-1:0] st_mem [FRAME_COUNT];
  logic [STAMP_W-1:0] st_rd;
  logic [FRAME_W-1:0] st_raddr;
  logic st_we;
  logic [FRAME_W-1:0] st_waddr;
  logic [STAMP_W-1:0] st_wdata;

  logic tlb_v [TLB_ENTRIES];
  logic [PAGE_W-1:0] tlb_p [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_f [TLB_ENTRIES];
  logic [TLB_W-1:0] tlb_ptr;
  logic [FRAME_W:0] frames_used;
  logic [FRAME_W-1:0] lo_ptr;
  logic [STAMP_W-1:0] clk_cnt;

  logic [ADDR_W-1:0] addr;
  logic [PAGE_W-1:0] page;
  logic [FRAME_W-1:0] frame;
  logic [PAGE_W-1:0] vpage;
  logic [FRAME_W-1:0] scan_idx, best;
  logic [STAMP_W-1:0] best_st;
  logic fault, evv;
  logic [PAGE_W-1:0] evp;
  logic out_v;
  rsp_t out_d;
  logic in_hold_v;
  logic [ADDR_W-1:0] in_hold;

  logic thit;
  logic [FRAME_W-1:0] tframe;
  logic [PAGE_W-1:0] npage;

  // Set while the eviction candidate came straight from the FIFO path.
  logic vpage_check;

  assign in_ch.ready = !in_hold_v;
  assign cfg.ready = 1'b1;
  assign out_ch.valid = out_v;
  assign out_ch.data = out_d;
  assign npage = in_hold[OFFSET_WIDTH +: PAGE_W];

  always_comb begin
    thit = 1'b0;
    tframe = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!thit && tlb_v[i] && tlb_p[i] == page) begin
        thit = 1'b1;
        tframe = tlb_f[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    pm_rd <= pm_mem[pm_raddr];
    if (own_we) begin
      own_mem[frame] <= page;
      q_mem[lo_ptr] <= page;
    end
    own_rd <= own_mem[own_raddr];
    q_rd <= q_mem[lo_ptr];
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rd <= st_mem[st_raddr];
  end

  always_comb begin
    pm_we = 1'b0;
    pm_waddr = page;
    pm_wdata = '0;
    pm_raddr = page;
    own_raddr = frame;
    own_we = 1'b0;
    st_we = 1'b0;
    st_waddr = frame;
    st_wdata = clk_cnt;
    st_raddr = scan_idx;
    unique case (state)
      S_CLEAR: begin
        pm_we = 1'b1;
        pm_waddr = clr_idx;
        st_we = 1'b1;
        st_waddr = clr_idx[FRAME_W-1:0];
        st_wdata = '0;
      end
      S_FIFO1: pm_raddr = q_rd;
      S_FIFO2: own_raddr = pm_rd[FRAME_W-1:0];
      S_EVICT: begin
        // The victim page is known only once the first pass through S_EVICT sets evv.
        pm_we = evv;
        pm_waddr = evp;
      end
      S_WRITE: begin
        st_we = 1'b1;
        if (fault) begin
          pm_we = 1'b1;
          pm_wdata = {1'b1, frame};
          own_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      mode <= 1'b0;
      tlb_ptr <= '0;
      frames_used <= '0;
      lo_ptr <= '0;
      clk_cnt <= '0;
      out_v <= 1'b0;
      in_hold_v <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) tlb_v[i] <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) mode <= cfg.data;
      if (in_ch.valid && in_ch.ready) begin
        in_hold_v <= 1'b1;
        in_hold <= in_ch.data.virt_addr;
      end
      if (out_ch.valid && out_ch.ready) out_v <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == PAGE_W'(PAGE_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_hold_v && !out_v) begin
            in_hold_v <= 1'b0;
            addr <= in_hold;
            page <= npage;
            clk_cnt <= clk_cnt + 1'b1;
            fault <= 1'b0;
            evv <= 1'b0;
            evp <= '0;
            state <= S_MAP;
          end
        end
        S_MAP: begin
          if (thit) begin
            frame <= tframe;
            state <= S_WRITE;
          end else state <= S_MAPD;
        end
        S_MAPD: begin
          if (pm_rd[FRAME_W]) begin
            frame <= pm_rd[FRAME_W-1:0];
            state <= S_WRITE;
          end else begin
            fault <= 1'b1;
            if (frames_used != (FRAME_W+1)'(FRAME_COUNT)) begin
              frame <= frames_used[FRAME_W-1:0];
              frames_used <= frames_used + 1'b1;
              state <= S_WRITE;
            end else if (!mode) state <= S_FIFO1;
            else begin
              scan_idx <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_FIFO1: begin
          vpage <= q_rd;
          state <= S_FIFO2;
        end
        S_FIFO2: begin
          if (pm_rd[FRAME_W]) begin
            frame <= pm_rd[FRAME_W-1:0];
            state <= S_EVICT;
          end else begin
            scan_idx <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Stamp of scan_idx-1 arrives this cycle.
          if (scan_idx == FRAME_W'(1)) begin
            best <= '0;
            best_st <= st_rd;
          end else if (scan_idx != '0 && st_rd < best_st) begin
            best <= scan_idx - 1'b1;
            best_st <= st_rd;
          end
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == FRAME_W'(FRAME_COUNT - 1)) state <= S_SCAN_END;
        end
        S_SCAN_END: begin
          // The stamp of the last frame arrives here.
          if (st_rd < best_st) frame <= FRAME_W'(FRAME_COUNT - 1);
          else frame <= best;
          state <= S_EVICTD;
        end
        S_EVICTD: state <= S_EVICT;
        S_EVICT: ;
        S_WRITE: begin
          if (!thit || fault) begin
            tlb_v[tlb_ptr] <= 1'b1;
            tlb_p[tlb_ptr] <= page;
            tlb_f[tlb_ptr] <= frame;
            tlb_ptr <= tlb_ptr + 1'b1;
          end
          if (fault) lo_ptr <= lo_ptr + 1'b1;
          out_v <= 1'b1;
          out_d.phys_addr <= PADDR_W'({frame, addr[OFFSET_WIDTH-1:0]});
          out_d.tlb_hit <= thit && !fault;
          out_d.page_fault <= fault;
          out_d.evicted_valid <= evv;
          out_d.evicted_page <= EVP_W'(evp);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // FIFO check: owner of the candidate frame must be the queued page.
      if (state == S_EVICT && !evv) begin
        if (mode == 1'b0 && fault && own_rd != vpage && vpage_check) begin
          scan_idx <= '0;
          state <= S_SCAN;
        end else begin
          evv <= 1'b1;
          evp <= own_rd;
          state <= S_EVICT;
        end
      end else if (state == S_EVICT) begin
        for (int i = 0; i < TLB_ENTRIES; i++)
          if (tlb_v[i] && tlb_p[i] == evp) tlb_v[i] <= 1'b0;
        state <= S_WRITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vpage_check <= 1'b0;
    else if (state == S_FIFO2) vpage_check <= 1'b1;
    else if (state == S_SCAN || state == S_IDLE) vpage_check <= 1'b0;
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the page translation unit with FIFO and LRU replacement.
`default_nettype none
module testbench;
  import tlbptu_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  tlbptu_if #(.payload_t(req_t)) in_if ();
  tlbptu_if #(.payload_t(rsp_t)) out_if ();
  tlbptu_if #(.payload_t(logic)) cfg_if ();

  tlb_page_translation_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg(cfg_if)
  );

  // Shadow copy of the translation state.
  logic                map_valid [PAGE_COUNT];
  logic [FRAME_W-1:0]  map_frame [PAGE_COUNT];
  logic                tlb_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0]   tlb_page [TLB_ENTRIES];
  logic [FRAME_W-1:0]  tlb_frame [TLB_ENTRIES];
  logic [TLB_W-1:0]    tlb_next;
  int unsigned         frames_taken;
  logic [PAGE_W-1:0]   load_queue [FRAME_COUNT];
  logic [FRAME_W-1:0]  load_next;
  logic [PAGE_W-1:0]   owner_of [FRAME_COUNT];
  logic [STAMP_W-1:0]  last_use [FRAME_COUNT];
  logic [STAMP_W-1:0]  use_count;
  logic                lru_mode;

  rsp_t        pending_xlat [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  function automatic logic [FRAME_W-1:0] oldest_frame();
    logic [FRAME_W-1:0] pick;
    pick = '0;
    for (int f = 1; f < FRAME_COUNT; f++)
      if (last_use[f] < last_use[pick]) pick = FRAME_W'(f);
    return pick;
  endfunction

  function automatic rsp_t translate(logic [ADDR_W-1:0] addr);
    rsp_t               r;
    logic [PAGE_W-1:0]  pg;
    logic [FRAME_W-1:0] fr;
    logic [PAGE_W-1:0]  victim;
    bit                 chosen;
    r  = '0;
    pg = addr[ADDR_W-1:OFFSET_WIDTH];
    fr = '0;
    use_count++;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!r.tlb_hit && tlb_valid[i] && tlb_page[i] == pg) begin
        r.tlb_hit = 1'b1;
        fr = tlb_frame[i];
      end
    end
    if (!r.tlb_hit) begin
      if (map_valid[pg]) begin
        fr = map_frame[pg];
      end else begin
        r.page_fault = 1'b1;
        if (frames_taken < FRAME_COUNT) begin
          fr = FRAME_W'(frames_taken);
          frames_taken++;
        end else begin
          chosen = 1'b0;
          if (!lru_mode) begin
            victim = load_queue[load_next];
            // A FIFO slot can be stale when LRU evictions ran in between.
            if (map_valid[victim] && owner_of[map_frame[victim]] == victim) begin
              fr = map_frame[victim];
              chosen = 1'b1;
            end
          end
          if (!chosen) fr = oldest_frame();
          r.evicted_valid = 1'b1;
          r.evicted_page  = owner_of[fr];
          map_valid[owner_of[fr]] = 1'b0;
          for (int i = 0; i < TLB_ENTRIES; i++)
            if (tlb_valid[i] && tlb_page[i] == owner_of[fr]) tlb_valid[i] = 1'b0;
        end
        map_valid[pg] = 1'b1;
        map_frame[pg] = fr;
        owner_of[fr]  = pg;
        load_queue[load_next] = pg;
        load_next++;
      end
      tlb_valid[tlb_next] = 1'b1;
      tlb_page[tlb_next]  = pg;
      tlb_frame[tlb_next] = fr;
      tlb_next++;
    end
    last_use[fr] = use_count;
    r.phys_addr = {fr, addr[OFFSET_WIDTH-1:0]};
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Random receiver stalls.
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= no_idle || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    rsp_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_xlat.size() == 0) begin
        report("unexpected translation beat", 32'(out_if.data.phys_addr), '0);
      end else begin
        want = pending_xlat.pop_front();
        if (out_if.data.phys_addr != want.phys_addr)
          report("phys_addr", 32'(out_if.data.phys_addr), 32'(want.phys_addr));
        if (out_if.data.tlb_hit != want.tlb_hit)
          report("tlb_hit", 32'(out_if.data.tlb_hit), 32'(want.tlb_hit));
        if (out_if.data.page_fault != want.page_fault)
          report("page_fault", 32'(out_if.data.page_fault), 32'(want.page_fault));
        if (out_if.data.evicted_valid != want.evicted_valid)
          report("evicted_valid", 32'(out_if.data.evicted_valid),
                 32'(want.evicted_valid));
        if (out_if.data.evicted_page != want.evicted_page)
          report("evicted_page", 32'(out_if.data.evicted_page), 32'(want.evicted_page));
      end
    end
  end

  // Sends one address beat and records its expected translation. Valid stays
  // high on return so that a following beat can go out back to back.
  task automatic send_addr(logic [ADDR_W-1:0] addr);
    if (!no_idle && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data.virt_addr <= addr;
    do @(posedge clk); while (!in_if.ready);
    pending_xlat.push_back(translate(addr));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    lru_mode = m;
  endtask

  function automatic logic [ADDR_W-1:0] mixed_addr();
    int unsigned sel;
    logic [PAGE_W-1:0] pg;
    sel = $urandom_range(99);
    if (sel < 55) pg = PAGE_W'($urandom_range(11));
    else if (sel < 85) pg = PAGE_W'($urandom_range(400, 100));
    else pg = PAGE_W'($urandom);
    return {pg, OFFSET_WIDTH'($urandom)};
  endfunction

  task automatic test_directed();
    send_addr('0);
    send_addr('1);
    send_addr('1);
    for (int p = 1; p <= 17; p++) send_addr({PAGE_W'(p), OFFSET_WIDTH'($urandom)});
    // Page 0 has left the TLB by now but still sits in the page map.
    send_addr({PAGE_W'(0), OFFSET_WIDTH'(10'h2AA)});
    send_addr({PAGE_W'(0), OFFSET_WIDTH'(10'h155)});
  endtask

  // Faults enough distinct pages to use up every frame and start evicting.
  task automatic test_frame_fill();
    for (int p = 600; p < 900; p++) send_addr({PAGE_W'(p), OFFSET_WIDTH'($urandom)});
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      send_addr(mixed_addr());
    end
    no_idle = 1'b0;
  endtask

  task automatic test_hold_off();
    send_addr(mixed_addr());
    in_if.valid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    send_addr(mixed_addr());
  endtask

  initial begin
    for (int p = 0; p < PAGE_COUNT; p++) map_valid[p] = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) tlb_valid[i] = 1'b0;
    for (int f = 0; f < FRAME_COUNT; f++) last_use[f] = '0;
    tlb_next = '0;
    frames_taken = 0;
    load_next = '0;
    use_count = '0;
    lru_mode = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = 1'b0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    write_mode(1'b0);
    test_frame_fill();
    test_random(120);
    write_mode(1'b1);
    test_random(120);
    test_hold_off();
    // Back to FIFO after LRU evictions, which leaves stale queue slots.
    write_mode(1'b0);
    test_random(80);
    write_mode(1'b1);
    test_random(60);

    drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
